// ----- rtl/frs_pkg.sv -----
`timescale 1ns / 1ps

package frs_pkg;

   // field widths
   localparam int PID_BITS   = 32;
   localparam int LOC_BITS   = 64;
   localparam int FRAME_BITS = 32;
   localparam int TIME_BITS  = 63;
   localparam int RATE_BITS  = 16;
   localparam int STAT_BITS  = 4;
   localparam int CFG8_BITS  = 8;

   // significant bits of the frame counter, 8 to 32
   localparam int COUNT_BITS = 32;

   // tenths of fps per frame per microsecond
   localparam int                    SCALE_BITS = 24;
   localparam logic [SCALE_BITS-1:0] TENTHS_SCALE = 24'd10_000_000;

   localparam int PROD_BITS    = COUNT_BITS + SCALE_BITS;
   localparam int DIV_CNT_BITS = $clog2(PROD_BITS);
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(PROD_BITS - 1);

   // configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DISCOVERY_DELAY = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETRY_TICKS     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_RATE        = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WARMUP_DISCARDS = 2'd3;

   localparam logic [CFG8_BITS-1:0] RST_DISCOVERY_DELAY = 8'd4;
   localparam logic [CFG8_BITS-1:0] RST_RETRY_TICKS     = 8'd5;
   localparam logic [RATE_BITS-1:0] RST_MAX_RATE        = 16'd1300;
   localparam logic [CFG8_BITS-1:0] RST_WARMUP_DISCARDS = 8'd1;

   // result status codes
   localparam logic [STAT_BITS-1:0] STAT_NONE     = 4'd0;
   localparam logic [STAT_BITS-1:0] STAT_DELAY    = 4'd1;
   localparam logic [STAT_BITS-1:0] STAT_RETRY    = 4'd2;
   localparam logic [STAT_BITS-1:0] STAT_LOC_FAIL = 4'd3;
   localparam logic [STAT_BITS-1:0] STAT_RD_FAIL  = 4'd4;
   localparam logic [STAT_BITS-1:0] STAT_BASELINE = 4'd5;
   localparam logic [STAT_BITS-1:0] STAT_NO_TIME  = 4'd6;
   localparam logic [STAT_BITS-1:0] STAT_WARMUP   = 4'd7;
   localparam logic [STAT_BITS-1:0] STAT_OVER_CAP = 4'd8;
   localparam logic [STAT_BITS-1:0] STAT_RATE     = 4'd9;

endpackage

// ----- rtl/frs_if.sv -----
`timescale 1ns / 1ps

interface frs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [frs_pkg::PID_BITS-1:0] process_id;
   logic                                locate_ok;
   logic [frs_pkg::LOC_BITS-1:0]        found_location;
   logic                                read_ok;
   logic [frs_pkg::FRAME_BITS-1:0]      frame_count;
   logic [frs_pkg::TIME_BITS-1:0]       time_us;

   modport source (output valid, process_id, locate_ok, found_location, read_ok,
                   frame_count, time_us, input ready);
   modport sink   (input valid, process_id, locate_ok, found_location, read_ok,
                   frame_count, time_us, output ready);
endinterface

interface frs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [frs_pkg::STAT_BITS-1:0] status;
   logic [frs_pkg::RATE_BITS-1:0] rate_tenths;
   logic                          process_changed;
   logic                          newly_located;
   logic [frs_pkg::LOC_BITS-1:0]  active_location;

   modport source (output valid, status, rate_tenths, process_changed, newly_located,
                   active_location, input ready);
   modport sink   (input valid, status, rate_tenths, process_changed, newly_located,
                   active_location, output ready);
endinterface

// ----- rtl/frs_mul.sv -----
`timescale 1ns / 1ps

// Bit-serial multiply by the tenths scale: one scale bit per cycle.
module frs_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [frs_pkg::COUNT_BITS-1:0]  delta,
   output logic                            done,
   output logic [frs_pkg::PROD_BITS-1:0]   product
);

   logic                             busy_ff;
   logic                             done_ff;
   logic [frs_pkg::PROD_BITS-1:0]    mcand_ff;
   logic [frs_pkg::SCALE_BITS-1:0]   mplier_ff;
   logic [frs_pkg::PROD_BITS-1:0]    acc_ff;
   logic [frs_pkg::PROD_BITS-1:0]    acc_in;

   assign acc_in = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && mplier_ff[frs_pkg::SCALE_BITS-1:1] == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff  <= {{(frs_pkg::PROD_BITS-frs_pkg::COUNT_BITS){1'b0}}, delta};
         mplier_ff <= frs_pkg::TENTHS_SCALE;
         acc_ff    <= '0;
      end else if (busy_ff) begin
         acc_ff    <= acc_in;
         mcand_ff  <= {mcand_ff[frs_pkg::PROD_BITS-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[frs_pkg::SCALE_BITS-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- rtl/frs_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first.
module frs_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [frs_pkg::PROD_BITS-1:0]  dividend,
   input  logic [frs_pkg::TIME_BITS-1:0]  divisor,
   output logic                           done,
   output logic [frs_pkg::PROD_BITS-1:0]  quotient
);

   logic                               busy_ff;
   logic                               done_ff;
   logic [frs_pkg::DIV_CNT_BITS-1:0]   cnt_ff;
   logic [frs_pkg::TIME_BITS-1:0]      rem_ff;
   logic [frs_pkg::TIME_BITS-1:0]      dsr_ff;
   logic [frs_pkg::PROD_BITS-1:0]      quo_ff;   // dividend shifts out, quotient in
   logic [frs_pkg::TIME_BITS:0]        trial;
   logic [frs_pkg::TIME_BITS:0]        diff;
   logic                               fits;
   logic [frs_pkg::TIME_BITS-1:0]      rem_in;

   assign trial  = {rem_ff, quo_ff[frs_pkg::PROD_BITS-1]};
   assign diff   = trial - {1'b0, dsr_ff};
   assign fits   = trial >= {1'b0, dsr_ff};
   assign rem_in = fits ? diff[frs_pkg::TIME_BITS-1:0] : trial[frs_pkg::TIME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dsr_ff <= divisor;
         quo_ff <= dividend;
         cnt_ff <= frs_pkg::DIV_LAST;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[frs_pkg::PROD_BITS-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/frame_rate_meter_sequencer.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// req_ch    in   valid/ready          process_id, locate_ok, found_location,
//                                     read_ok, frame_count, time_us
// rsp_ch    out  valid/ready          status, rate_tenths, process_changed,
//                                     newly_located, active_location
// csr_*     in   csr_we (no ready)    csr_index, csr_wdata
//
// A tick that needs no division passes from accept through EVAL and EMIT to the output register.
// A tick that is divided (rate or over cap) runs EVAL, the bit-serial scale multiplier,
// the one-bit-per-cycle divider and then EMIT.
// One tick is in flight at a time; the next is taken while a word waits on rsp_ch.
// Reset is synchronous, active high, and restores the configuration registers and tracking state.
// A stalled rsp_ch holds the finished word and, after that, the next one in flight.
module frame_rate_meter_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   frs_req_if.sink                              req_ch,
   frs_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [frs_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [frs_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   localparam int CB = frs_pkg::COUNT_BITS;
   localparam int TB = frs_pkg::TIME_BITS;
   localparam int PB = frs_pkg::PROD_BITS;
   localparam int RB = frs_pkg::RATE_BITS;

   logic [2:0] state_ff;

   // configuration
   logic [frs_pkg::CFG8_BITS-1:0] disc_delay_ff;
   logic [frs_pkg::CFG8_BITS-1:0] retry_ticks_ff;
   logic [RB-1:0]                 max_rate_ff;
   logic [frs_pkg::CFG8_BITS-1:0] warm_disc_ff;

   // latched tick
   logic [frs_pkg::PID_BITS-1:0]  in_pid_ff;
   logic                          in_locate_ff;
   logic [frs_pkg::LOC_BITS-1:0]  in_found_ff;
   logic                          in_read_ff;
   logic [CB-1:0]                 in_count_ff;
   logic [TB-1:0]                 in_time_ff;

   // tracking state
   logic [frs_pkg::PID_BITS-1:0]  tracked_ff,    tracked_in;
   logic                          loc_valid_ff,  loc_valid_in;
   logic [frs_pkg::LOC_BITS-1:0]  held_loc_ff,   held_loc_in;
   logic [CB-1:0]                 last_count_ff, last_count_in;
   logic [TB-1:0]                 last_time_ff,  last_time_in;
   logic                          base_held_ff,  base_held_in;
   logic [7:0]                    warm_left_ff,  warm_left_in;
   logic [7:0]                    ticks_ff,      ticks_in;
   logic [7:0]                    retry_ff,      retry_in;

   // evaluation
   logic                          chg;
   logic                          no_proc;
   logic                          go_read;
   logic [frs_pkg::STAT_BITS-1:0] ev_status;
   logic                          ev_located;
   logic                          ev_div;
   logic [CB-1:0]                 delta;
   logic [TB-1:0]                 elapsed_ff;

   // pending result
   logic [frs_pkg::STAT_BITS-1:0] res_status_ff;
   logic [RB-1:0]                 res_rate_ff;
   logic                          res_changed_ff;
   logic                          res_located_ff;
   logic [frs_pkg::LOC_BITS-1:0]  res_loc_ff;

   // output register
   logic                          rsp_valid_ff;
   logic [frs_pkg::STAT_BITS-1:0] rsp_status_ff;
   logic [RB-1:0]                 rsp_rate_ff;
   logic                          rsp_changed_ff;
   logic                          rsp_located_ff;
   logic [frs_pkg::LOC_BITS-1:0]  rsp_loc_ff;
   logic                          load_out;

   // arithmetic
   logic                          mul_start;
   logic                          mul_done;
   logic [PB-1:0]                 mul_prod;
   logic                          div_done;
   logic [PB-1:0]                 quo;
   logic [PB-1:0]                 cap_ext;
   logic                          over_cap;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign load_out     = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         disc_delay_ff  <= frs_pkg::RST_DISCOVERY_DELAY;
         retry_ticks_ff <= frs_pkg::RST_RETRY_TICKS;
         max_rate_ff    <= frs_pkg::RST_MAX_RATE;
         warm_disc_ff   <= frs_pkg::RST_WARMUP_DISCARDS;
      end else if (csr_we) begin
         case (csr_index)
            frs_pkg::CSR_DISCOVERY_DELAY: disc_delay_ff  <= csr_wdata[7:0];
            frs_pkg::CSR_RETRY_TICKS:     retry_ticks_ff <= csr_wdata[7:0];
            frs_pkg::CSR_MAX_RATE:        max_rate_ff    <= csr_wdata[RB-1:0];
            frs_pkg::CSR_WARMUP_DISCARDS: warm_disc_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_pid_ff    <= req_ch.process_id;
         in_locate_ff <= req_ch.locate_ok;
         in_found_ff  <= req_ch.found_location;
         in_read_ff   <= req_ch.read_ok;
         in_count_ff  <= req_ch.frame_count[CB-1:0];
         in_time_ff   <= req_ch.time_us;
      end
   end

   assign chg     = in_pid_ff != tracked_ff;
   assign no_proc = (in_pid_ff == '0) || in_pid_ff[frs_pkg::PID_BITS-1];
   assign delta   = in_count_ff - last_count_ff;

   // one tick of the tracking sequence, decided in the EVAL cycle
   always_comb begin
      tracked_in    = in_pid_ff;
      loc_valid_in  = loc_valid_ff & ~chg;
      held_loc_in   = held_loc_ff;
      last_count_in = chg ? '0 : last_count_ff;
      last_time_in  = chg ? '0 : last_time_ff;
      base_held_in  = base_held_ff & ~chg;
      warm_left_in  = chg ? warm_disc_ff : warm_left_ff;
      ticks_in      = chg ? 8'd0 : ticks_ff;
      retry_in      = chg ? 8'd0 : retry_ff;
      ev_status     = frs_pkg::STAT_NONE;
      ev_located    = 1'b0;
      ev_div        = 1'b0;
      go_read       = 1'b0;
      if (!no_proc) begin
         if (ticks_in != 8'hFF) begin
            ticks_in = ticks_in + 8'd1;
         end
         go_read = 1'b1;
         if (!loc_valid_in) begin
            if (ticks_in < disc_delay_ff) begin
               ev_status = frs_pkg::STAT_DELAY;
               go_read   = 1'b0;
            end else if (retry_in != 8'd0) begin
               retry_in  = retry_in - 8'd1;
               ev_status = frs_pkg::STAT_RETRY;
               go_read   = 1'b0;
            end else if (!in_locate_ff) begin
               retry_in  = retry_ticks_ff;
               ev_status = frs_pkg::STAT_LOC_FAIL;
               go_read   = 1'b0;
            end else begin
               loc_valid_in = 1'b1;
               held_loc_in  = in_found_ff;
               base_held_in = 1'b0;
               warm_left_in = warm_disc_ff;
               ev_located   = 1'b1;
            end
         end
         if (go_read) begin
            if (!in_read_ff) begin
               loc_valid_in = 1'b0;
               base_held_in = 1'b0;
               warm_left_in = warm_disc_ff;
               retry_in     = retry_ticks_ff;
               ev_status    = frs_pkg::STAT_RD_FAIL;
            end else if (!base_held_in) begin
               last_count_in = in_count_ff;
               last_time_in  = in_time_ff;
               base_held_in  = 1'b1;
               ev_status     = frs_pkg::STAT_BASELINE;
            end else begin
               last_count_in = in_count_ff;
               last_time_in  = in_time_ff;
               if (in_time_ff > last_time_ff) begin
                  if (warm_left_in != 8'd0) begin
                     warm_left_in = warm_left_in - 8'd1;
                     ev_status    = frs_pkg::STAT_WARMUP;
                  end else begin
                     ev_div = 1'b1;
                  end
               end else begin
                  ev_status = frs_pkg::STAT_NO_TIME;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_ff    <= '1;
         loc_valid_ff  <= 1'b0;
         last_count_ff <= '0;
         last_time_ff  <= '0;
         base_held_ff  <= 1'b0;
         warm_left_ff  <= 8'd1;
         ticks_ff      <= 8'd0;
         retry_ff      <= 8'd0;
      end else if (state_ff == S_EVAL) begin
         tracked_ff    <= tracked_in;
         loc_valid_ff  <= loc_valid_in;
         last_count_ff <= last_count_in;
         last_time_ff  <= last_time_in;
         base_held_ff  <= base_held_in;
         warm_left_ff  <= warm_left_in;
         ticks_ff      <= ticks_in;
         retry_ff      <= retry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         held_loc_ff    <= held_loc_in;
         elapsed_ff     <= in_time_ff - last_time_ff;
         res_changed_ff <= chg;
         res_located_ff <= ev_located;
         res_loc_ff     <= loc_valid_in ? held_loc_in : '0;
         res_status_ff  <= ev_status;
         res_rate_ff    <= '0;
      end else if (state_ff == S_DIV && div_done) begin
         res_status_ff <= over_cap ? frs_pkg::STAT_OVER_CAP : frs_pkg::STAT_RATE;
         res_rate_ff   <= over_cap ? '0 : quo[RB-1:0];
      end
   end

   assign mul_start = (state_ff == S_EVAL) && ev_div;
   assign cap_ext   = {{(PB-RB){1'b0}}, max_rate_ff};
   assign over_cap  = quo > cap_ext;

   frs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .delta   (delta),
      .done    (mul_done),
      .product (mul_prod)
   );

   frs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_MUL && mul_done),
      .dividend (mul_prod),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (req_ch.valid) state_ff <= S_EVAL;
            S_EVAL: state_ff <= ev_div ? S_MUL : S_EMIT;
            S_MUL:  if (mul_done) state_ff <= S_DIV;
            S_DIV:  if (div_done) state_ff <= S_EMIT;
            S_EMIT: if (load_out) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_status_ff  <= res_status_ff;
         rsp_rate_ff    <= res_rate_ff;
         rsp_changed_ff <= res_changed_ff;
         rsp_located_ff <= res_located_ff;
         rsp_loc_ff     <= res_loc_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.rate_tenths     = rsp_rate_ff;
   assign rsp_ch.process_changed = rsp_changed_ff;
   assign rsp_ch.newly_located   = rsp_located_ff;
   assign rsp_ch.active_location = rsp_loc_ff;

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == S_EVAL)
      else $error("accepted word did not enter evaluation");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_MUL)
      else $error("multiplier finished outside its wait state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");

   a_rate_in_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == frs_pkg::STAT_RATE |->
         rsp_ch.rate_tenths <= max_rate_ff)
      else $error("reported rate above cap");

endmodule

// ----- dv/tb_frame_rate_meter_sequencer.sv -----
`timescale 1ns / 1ps

typedef struct packed {
   logic signed [frs_pkg::PID_BITS-1:0] process_id;
   logic                                locate_ok;
   logic [frs_pkg::LOC_BITS-1:0]        found_location;
   logic                                read_ok;
   logic [frs_pkg::FRAME_BITS-1:0]      frame_count;
   logic [frs_pkg::TIME_BITS-1:0]       time_us;
} tick_type;

typedef struct packed {
   logic [frs_pkg::STAT_BITS-1:0] status;
   logic [frs_pkg::RATE_BITS-1:0] rate_tenths;
   logic                          process_changed;
   logic                          newly_located;
   logic [frs_pkg::LOC_BITS-1:0]  active_location;
} report_type;

class meter_scoreboard;
   // register copies
   bit [7:0]  cfg_delay;
   bit [7:0]  cfg_retry;
   bit [15:0] cfg_cap;
   bit [7:0]  cfg_warmup;

   // tracking state
   bit [31:0] tracked_pid;
   bit        loc_held;
   bit [63:0] held_loc;
   bit [31:0] prev_count;
   bit [63:0] prev_time;
   bit        base_valid;
   bit [7:0]  warmup_left;
   bit [7:0]  ticks_seen;
   bit [7:0]  retry_left;

   report_type owed_reports[$];
   int         errors;
   int         checked;
   int         seen[16];

   function new();
      cfg_delay     = frs_pkg::RST_DISCOVERY_DELAY;
      cfg_retry     = frs_pkg::RST_RETRY_TICKS;
      cfg_cap       = frs_pkg::RST_MAX_RATE;
      cfg_warmup    = frs_pkg::RST_WARMUP_DISCARDS;
      tracked_pid   = 32'hFFFF_FFFF;
      loc_held      = 1'b0;
      held_loc      = '0;
      prev_count    = '0;
      prev_time     = '0;
      base_valid    = 1'b0;
      warmup_left   = 8'd1;
      ticks_seen    = '0;
      retry_left    = '0;
      errors        = 0;
      checked       = 0;
      foreach (seen[i]) seen[i] = 0;
   endfunction

   function void set_config(bit [7:0] delay, bit [7:0] retry, bit [15:0] cap,
                            bit [7:0] warmup);
      cfg_delay  = delay;
      cfg_retry  = retry;
      cfg_cap    = cap;
      cfg_warmup = warmup;
   endfunction

   function int pending();
      return owed_reports.size();
   endfunction

   // advance the tracking state by one accepted tick and queue the word it owes
   function void note_tick(tick_type t);
      report_type r;
      bit [31:0] pid;
      bit [31:0] cnt;
      bit [31:0] mask;
      bit [31:0] delta;
      bit [63:0] now;
      bit [63:0] elapsed;
      bit [63:0] quotient;
      bit        go_on;
      r     = '0;
      pid   = t.process_id;
      mask  = 32'hFFFF_FFFF >> (32 - frs_pkg::COUNT_BITS);
      cnt   = t.frame_count & mask;
      now   = {1'b0, t.time_us};
      r.status = frs_pkg::STAT_NONE;
      if (pid != tracked_pid) begin
         r.process_changed = 1'b1;
         tracked_pid   = pid;
         loc_held      = 1'b0;
         held_loc      = '0;
         prev_count    = '0;
         prev_time     = '0;
         base_valid    = 1'b0;
         warmup_left   = cfg_warmup;
         ticks_seen    = '0;
         retry_left    = '0;
      end
      if (pid != 0 && !pid[31]) begin
         if (ticks_seen != 8'hFF) ticks_seen++;
         go_on = 1'b1;
         if (!loc_held) begin
            if (ticks_seen < cfg_delay) begin
               r.status = frs_pkg::STAT_DELAY;
               go_on = 1'b0;
            end else if (retry_left != 0) begin
               retry_left--;
               r.status = frs_pkg::STAT_RETRY;
               go_on = 1'b0;
            end else if (!t.locate_ok) begin
               retry_left = cfg_retry;
               r.status = frs_pkg::STAT_LOC_FAIL;
               go_on = 1'b0;
            end else begin
               // located: the same tick goes on to the read
               loc_held        = 1'b1;
               held_loc        = t.found_location;
               base_valid      = 1'b0;
               warmup_left     = cfg_warmup;
               r.newly_located = 1'b1;
            end
         end
         if (go_on) begin
            if (!t.read_ok) begin
               loc_held      = 1'b0;
               held_loc      = '0;
               base_valid    = 1'b0;
               warmup_left   = cfg_warmup;
               retry_left    = cfg_retry;
               r.status      = frs_pkg::STAT_RD_FAIL;
            end else if (!base_valid) begin
               prev_count    = cnt;
               prev_time     = now;
               base_valid    = 1'b1;
               r.status      = frs_pkg::STAT_BASELINE;
            end else begin
               r.status = frs_pkg::STAT_NO_TIME;
               if (now > prev_time) begin
                  elapsed  = now - prev_time;
                  delta    = (cnt - prev_count) & mask;
                  quotient = (64'(delta) * 64'(frs_pkg::TENTHS_SCALE)) / elapsed;
                  if (warmup_left != 0) begin
                     warmup_left--;
                     r.status = frs_pkg::STAT_WARMUP;
                  end else if (quotient > 64'(cfg_cap)) begin
                     r.status = frs_pkg::STAT_OVER_CAP;
                  end else begin
                     r.status      = frs_pkg::STAT_RATE;
                     r.rate_tenths = quotient[15:0];
                  end
               end
               // baseline moves even when no time elapsed
               prev_count = cnt;
               prev_time  = now;
            end
         end
      end
      r.active_location = loc_held ? held_loc : 64'd0;
      owed_reports.push_back(r);
   endfunction

   function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         errors++;
      end
   endfunction

   function void check_report(report_type got);
      report_type want;
      if (owed_reports.size() == 0) begin
         $error("unexpected rsp word: status 0x%0h", got.status);
         errors++;
         return;
      end
      want = owed_reports.pop_front();
      checked++;
      if (!$isunknown(got.status)) seen[got.status]++;
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("rate_tenths", 64'(want.rate_tenths), 64'(got.rate_tenths));
      compare_field("process_changed", 64'(want.process_changed), 64'(got.process_changed));
      compare_field("newly_located", 64'(want.newly_located), 64'(got.newly_located));
      compare_field("active_location", want.active_location, got.active_location);
   endfunction
endclass

module tb_frame_rate_meter_sequencer;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 120;

   logic                                     clock = 1'b0;
   logic                                     reset;
   logic                                     csr_we;
   logic [frs_pkg::CSR_IDX_BITS-1:0]         csr_index;
   logic [frs_pkg::CSR_DATA_BITS-1:0]        csr_wdata;

   frs_req_if req_ch ();
   frs_rsp_if rsp_ch ();

   meter_scoreboard sb;
   int send_idle;
   int recv_idle;
   int cycle_count = 0;

   frame_rate_meter_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: check accepted words, then pick next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_report({rsp_ch.status, rsp_ch.rate_tenths, rsp_ch.process_changed,
                             rsp_ch.newly_located, rsp_ch.active_location});
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   function automatic tick_type mk_tick(logic [31:0] pid, logic lok, logic [63:0] loc,
                                        logic rok, logic [31:0] cnt, logic [62:0] tus);
      tick_type t;
      t.process_id     = pid;
      t.locate_ok      = lok;
      t.found_location = loc;
      t.read_ok        = rok;
      t.frame_count    = cnt;
      t.time_us        = tus;
      return t;
   endfunction

   // valid stays high straight into the next word unless an idle cycle is drawn
   task automatic push_tick(input tick_type t);
      while ($urandom_range(0, 99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.process_id     <= t.process_id;
      req_ch.locate_ok      <= t.locate_ok;
      req_ch.found_location <= t.found_location;
      req_ch.read_ok        <= t.read_ok;
      req_ch.frame_count    <= t.frame_count;
      req_ch.time_us        <= t.time_us;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_tick(t);
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input bit [7:0] delay, input bit [7:0] retry,
                            input bit [15:0] cap, input bit [7:0] warmup);
      csr_we    <= 1'b1;
      csr_index <= frs_pkg::CSR_DISCOVERY_DELAY;
      csr_wdata <= 16'(delay);
      @(posedge clock);
      csr_index <= frs_pkg::CSR_RETRY_TICKS;
      csr_wdata <= 16'(retry);
      @(posedge clock);
      csr_index <= frs_pkg::CSR_MAX_RATE;
      csr_wdata <= cap;
      @(posedge clock);
      csr_index <= frs_pkg::CSR_WARMUP_DISCARDS;
      csr_wdata <= 16'(warmup);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_config(delay, retry, cap, warmup);
   endtask

   // runs at reset register values: delay 4, retry 5, cap 1300, one warmup
   task automatic run_directed();
      logic [31:0] c0;
      logic [62:0] t0;
      c0 = 32'hFFFF_FFF0;
      t0 = 63'd5_000_000;
      push_tick(mk_tick(32'd0, 1'b1, '0, 1'b1, '0, '0));
      push_tick(mk_tick(32'h8000_0000, 1'b1, '1, 1'b1, '1, '1));
      repeat (3) push_tick(mk_tick(32'd7, 1'b1, '1, 1'b1, c0, t0));
      push_tick(mk_tick(32'd7, 1'b0, '1, 1'b1, c0, t0));
      repeat (5) push_tick(mk_tick(32'd7, 1'b0, '1, 1'b1, c0, t0));
      // zero is a real location
      push_tick(mk_tick(32'd7, 1'b1, 64'd0, 1'b1, c0, t0));
      push_tick(mk_tick(32'd7, 1'b1, '1, 1'b1, c0, t0));
      push_tick(mk_tick(32'd7, 1'b1, '1, 1'b1, c0 + 32'd60, t0 + 63'd1_000_000));
      push_tick(mk_tick(32'd7, 1'b1, '1, 1'b1, c0 + 32'd120, t0 + 63'd2_000_000));
      // exactly at the cap, then above it
      push_tick(mk_tick(32'd7, 1'b1, '1, 1'b1, c0 + 32'd250, t0 + 63'd3_000_000));
      push_tick(mk_tick(32'd7, 1'b1, '1, 1'b1, c0 + 32'd450, t0 + 63'd4_000_000));
      push_tick(mk_tick(32'd7, 1'b1, '1, 1'b1, c0 + 32'd449, t0 + 63'd4_000_001));
      push_tick(mk_tick(32'd7, 1'b1, '1, 1'b0, c0, t0 + 63'd5_000_000));
      push_tick(mk_tick(32'h7FFF_FFFF, 1'b1, '1, 1'b0, '1, '1));
      push_tick(mk_tick(32'hFFFF_FFFF, 1'b1, '1, 1'b1, '0, '0));
      req_ch.valid <= 1'b0;
   endtask

   // sessions on one process with a running clock and counter; noise swaps in
   // stray process ids
   task automatic run_phase(input int n_items, input int sess_lo, input int sess_hi,
                            input int fail_pct, input int noise_pct);
      int          sent;
      int          sess_len;
      int          roll;
      logic [31:0] pid;
      logic [62:0] clk_us;
      logic [31:0] frames;
      logic [63:0] gap;
      logic [63:0] dmax;
      tick_type    t;
      sent = 0;
      while (sent < n_items) begin
         pid = $urandom_range(1, 32'h7FFF_FFFF);
         roll = $urandom_range(0, 19);
         if (roll == 0) pid = 32'h7FFF_FFFF;
         else if (roll == 1) pid = 32'd1;
         clk_us   = 63'({$urandom, $urandom});
         frames   = $urandom;
         sess_len = $urandom_range(sess_lo, sess_hi);
         for (int k = 0; k < sess_len && sent < n_items; k++) begin
            t.process_id = pid;
            if ($urandom_range(0, 99) < noise_pct)
               t.process_id = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
            t.locate_ok      = ($urandom_range(0, 99) < 85);
            t.found_location = ($urandom_range(0, 15) == 0) ? 64'd0 : {$urandom, $urandom};
            t.read_ok        = ($urandom_range(0, 99) >= fail_pct);
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               gap = 0;
            end else if (roll < 6) begin
               clk_us = clk_us - 63'($urandom_range(1, 1000));
               gap = 0;
            end else if (roll < 10) begin
               gap = $urandom_range(1, 1000);
            end else if (roll < 11) begin
               gap = {$urandom, $urandom} >> 2;
            end else begin
               gap = $urandom_range(900_000, 1_100_000);
            end
            clk_us = clk_us + gap[62:0];
            // counter step sized to land around the cap
            if (gap > 64'd1_000_000_000)
               dmax = 64'hFFFF_FFFF;
            else
               dmax = ((64'(sb.cfg_cap) + sb.cfg_cap / 4 + 4) * gap) / 64'd10_000_000;
            if (dmax > 64'hFFFF_FFFF) dmax = 64'hFFFF_FFFF;
            if ($urandom_range(0, 49) == 0)
               frames = $urandom;
            else
               frames = frames + $urandom_range(0, dmax[31:0]);
            t.frame_count = frames;
            t.time_us     = clk_us;
            push_tick(t);
            sent++;
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      sb = new();
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= '0;
      csr_wdata             <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.process_id     <= '0;
      req_ch.locate_ok      <= 1'b0;
      req_ch.found_location <= '0;
      req_ch.read_ok        <= 1'b0;
      req_ch.frame_count    <= '0;
      req_ch.time_us        <= '0;
      send_idle = 29;
      recv_idle = 88;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain();

      configure(8'd0, 8'd0, 16'hFFFF, 8'd0);
      run_phase(300, 5, 40, 8, 4);
      drain();
      // long single-process runs push the tick count into saturation
      configure(8'd255, 8'd255, 16'd0, 8'd0);
      run_phase(300, 300, 300, 5, 0);
      drain();

      send_idle = 88;
      recv_idle = 29;
      configure(8'd1, 8'd0, 16'd2000, 8'd255);
      run_phase(300, 300, 300, 0, 0);
      drain();
      configure(8'd2, 8'd3, 16'd1300, 8'd2);
      run_phase(300, 4, 30, 8, 5);
      drain();

      send_idle = 0;
      recv_idle = 0;
      configure(8'd1, 8'd1, 16'd800, 8'd1);
      run_phase(300, 3, 25, 10, 6);
      drain();

      $display("%0d ticks checked over reset values and five register settings, %0s",
               sb.checked, "under three idling profiles");
      $display("rate %0d, over cap %0d, warmup %0d, no time %0d, baseline %0d, %0s %0d",
               sb.seen[frs_pkg::STAT_RATE], sb.seen[frs_pkg::STAT_OVER_CAP],
               sb.seen[frs_pkg::STAT_WARMUP], sb.seen[frs_pkg::STAT_NO_TIME],
               sb.seen[frs_pkg::STAT_BASELINE], "read fail",
               sb.seen[frs_pkg::STAT_RD_FAIL]);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
